>>> rtl/ddse_pkg.sv
// Shared types, constants and tables for the decimal digit sprite emitter.
package ddse_pkg;

    localparam int VALUE_W        = 27;
    localparam int COORD_W        = 16;
    localparam int WORD_W         = 16;
    localparam int U_W            = 7;
    localparam int LIMIT_W        = 34;
    localparam int DEF_MAX_DIGITS = 8;
    localparam int CFG_IDX_W      = 2;

    localparam logic [1:0] KIND_DIGIT   = 2'd0;
    localparam logic [1:0] KIND_OUTLINE = 2'd1;
    localparam logic [1:0] KIND_TPAGE   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PAL_NORMAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAL_ONE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAL_TWO    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TPAGE      = 2'd3;

    localparam logic [WORD_W-1:0] RST_PAL_NORMAL = 16'd31491;
    localparam logic [WORD_W-1:0] RST_PAL_ONE    = 16'd31432;
    localparam logic [WORD_W-1:0] RST_PAL_TWO    = 16'd31433;
    localparam logic [WORD_W-1:0] RST_TPAGE      = 16'd7;

    localparam logic [6:0] STYLE_ONE = 7'd1;
    localparam logic [6:0] STYLE_TWO = 7'd2;

    typedef struct packed {
        logic [VALUE_W-1:0]        number_value;
        logic [3:0]                digit_width;
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic [6:0]                style_select;
        logic                      outline_enable;
    } t_in_item;

    typedef struct packed {
        logic [1:0]                record_kind;
        logic signed [COORD_W-1:0] sprite_x;
        logic signed [COORD_W-1:0] sprite_y;
        logic [U_W-1:0]            glyph_u;
        logic [WORD_W-1:0]         palette_word;
        logic signed [COORD_W-1:0] end_x;
        logic                      last_record;
    } t_out_item;

    // 10^n for the clamped field width
    function automatic logic [LIMIT_W-1:0] pow10(input logic [3:0] n);
        logic [LIMIT_W-1:0] r;
        case (n)
            4'd0:    r = 34'd1;
            4'd1:    r = 34'd10;
            4'd2:    r = 34'd100;
            4'd3:    r = 34'd1000;
            4'd4:    r = 34'd10000;
            4'd5:    r = 34'd100000;
            4'd6:    r = 34'd1000000;
            4'd7:    r = 34'd10000000;
            4'd8:    r = 34'd100000000;
            4'd9:    r = 34'd1000000000;
            default: r = '1;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/decimal_digit_sprite_emitter.sv
// Decimal digit sprite emitter top level: item sequencer and record output.
// Takes a new item only while idle. Its value is converted to BCD one bit per cycle, then
// the digit and outline records go out one per cycle, save where the output stalls or a
// leading zero is skipped, and a closing texture page record ends the item.
// Synchronous active-low reset restores the palette registers and idles the block.
module decimal_digit_sprite_emitter #(
    parameter int MAX_DIGITS = ddse_pkg::DEF_MAX_DIGITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  ddse_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output ddse_pkg::t_out_item             o_out_data,
    input  logic                            i_cfg_we,
    input  logic [ddse_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ddse_pkg::WORD_W-1:0]     i_cfg_data
);
    import ddse_pkg::*;

    localparam int K_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    typedef enum logic [1:0] {S_IDLE, S_CONV, S_EMIT, S_TPAGE} t_state;

    t_state              r_state;
    logic [WORD_W-1:0]   r_pal_normal;
    logic [WORD_W-1:0]   r_pal_one;
    logic [WORD_W-1:0]   r_pal_two;
    logic [WORD_W-1:0]   r_tpage;

    logic [3:0]          r_width;
    logic [COORD_W-1:0]  r_sx;
    logic [COORD_W-1:0]  r_sy;
    logic [COORD_W-1:0]  r_ex;
    logic [WORD_W-1:0]   r_pal;
    logic                r_outline;
    logic [K_W-1:0]      r_k;
    logic                r_lead;
    logic [2:0]          r_sub;
    logic                r_out_valid;
    t_out_item           r_out;

    logic                in_accept;
    logic                can_load;
    logic                load_out;
    logic [3:0]          n_width;
    logic [LIMIT_W-1:0]  n_limit;
    logic [VALUE_W-1:0]  n_value;
    logic                conv_done;
    logic [4*MAX_DIGITS-1:0] conv_bcd;
    logic [3:0]          cur_digit;
    logic [3:0]          cur_pos;
    logic [COORD_W-1:0]  cur_x;
    logic                skip;
    logic                digit_end;

    assign in_accept = i_in_valid && !o_in_stall;
    assign can_load  = !r_out_valid || !i_out_stall;

    always_comb begin
        if (i_in_data.digit_width == 4'd0) begin
            n_width = 4'd1;
        end else if (i_in_data.digit_width > 4'(MAX_DIGITS)) begin
            n_width = 4'(MAX_DIGITS);
        end else begin
            n_width = i_in_data.digit_width;
        end
        n_limit = pow10(n_width);
        if (LIMIT_W'(i_in_data.number_value) >= n_limit) begin
            n_value = VALUE_W'(n_limit - 1'b1);
        end else begin
            n_value = i_in_data.number_value;
        end
    end

    ddse_bcd_conv #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_accept),
        .i_value (n_value),
        .o_done  (conv_done),
        .o_bcd   (conv_bcd)
    );

    assign cur_digit = conv_bcd[4*r_k +: 4];
    assign cur_pos   = r_width - 4'd1 - 4'(r_k);
    assign cur_x     = r_sx + {9'd0, cur_pos, 3'd0};
    assign skip      = r_lead && (cur_digit == 4'd0) && (r_k != '0);
    assign digit_end = (r_sub == 3'd4) || ((r_sub == 3'd0) && !r_outline);
    assign load_out  = can_load && (((r_state == S_EMIT) && !skip) || (r_state == S_TPAGE));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_pal_normal <= RST_PAL_NORMAL;
            r_pal_one    <= RST_PAL_ONE;
            r_pal_two    <= RST_PAL_TWO;
            r_tpage      <= RST_TPAGE;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PAL_NORMAL: r_pal_normal <= i_cfg_data;
                    CFG_PAL_ONE:    r_pal_one    <= i_cfg_data;
                    CFG_PAL_TWO:    r_pal_two    <= i_cfg_data;
                    CFG_TPAGE:      r_tpage      <= i_cfg_data;
                    default: ;
                endcase
            end

            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_state   <= S_CONV;
                        r_width   <= n_width;
                        r_sx      <= i_in_data.start_x;
                        r_sy      <= i_in_data.start_y;
                        r_ex      <= i_in_data.start_x + {9'd0, n_width, 3'd0};
                        r_outline <= i_in_data.outline_enable;
                        if (i_in_data.style_select == STYLE_ONE) begin
                            r_pal <= r_pal_one;
                        end else if (i_in_data.style_select == STYLE_TWO) begin
                            r_pal <= r_pal_two;
                        end else begin
                            r_pal <= r_pal_normal;
                        end
                    end
                end
                S_CONV: begin
                    if (conv_done) begin
                        r_state <= S_EMIT;
                        r_k     <= K_W'(r_width - 4'd1);
                        r_lead  <= 1'b1;
                        r_sub   <= 3'd0;
                    end
                end
                S_EMIT: begin
                    if (skip) begin
                        r_k <= r_k - 1'b1;
                    end else if (can_load) begin
                        r_lead               <= 1'b0;
                        r_out.record_kind    <= (r_sub == 3'd0) ? KIND_DIGIT : KIND_OUTLINE;
                        r_out.sprite_x       <= (r_sub == 3'd1) ? cur_x + 16'd1 :
                                                (r_sub == 3'd2) ? cur_x - 16'd1 : cur_x;
                        r_out.sprite_y       <= (r_sub == 3'd3) ? r_sy + 16'd1 :
                                                (r_sub == 3'd4) ? r_sy - 16'd1 : r_sy;
                        r_out.glyph_u        <= {cur_digit, 3'd0};
                        r_out.palette_word   <= r_pal;
                        r_out.end_x          <= r_ex;
                        r_out.last_record    <= 1'b0;
                        if (digit_end) begin
                            r_sub <= 3'd0;
                            if (r_k == '0) begin
                                r_state <= S_TPAGE;
                            end else begin
                                r_k <= r_k - 1'b1;
                            end
                        end else begin
                            r_sub <= r_sub + 3'd1;
                        end
                    end
                end
                S_TPAGE: begin
                    if (can_load) begin
                        r_out.record_kind  <= KIND_TPAGE;
                        r_out.sprite_x     <= '0;
                        r_out.sprite_y     <= '0;
                        r_out.glyph_u      <= '0;
                        r_out.palette_word <= r_tpage;
                        r_out.end_x        <= r_ex;
                        r_out.last_record  <= 1'b1;
                        r_state            <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> rtl/ddse_bcd_conv.sv
// Iterative shift-and-add-3 binary to BCD converter, one bit per cycle.
module ddse_bcd_conv #(
    parameter int MAX_DIGITS = ddse_pkg::DEF_MAX_DIGITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ddse_pkg::VALUE_W-1:0]  i_value,
    output logic                          o_done,
    output logic [4*MAX_DIGITS-1:0]       o_bcd
);
    import ddse_pkg::*;

    localparam int BCD_W = 4 * MAX_DIGITS;
    localparam int CNT_W = $clog2(VALUE_W);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [VALUE_W-1:0] r_bin;
    logic [BCD_W-1:0]   r_bcd;
    logic [BCD_W-1:0]   n_adj;

    always_comb begin
        for (int d = 0; d < MAX_DIGITS; d++) begin
            if (r_bcd[4*d +: 4] >= 4'd5) begin
                n_adj[4*d +: 4] = r_bcd[4*d +: 4] + 4'd3;
            end else begin
                n_adj[4*d +: 4] = r_bcd[4*d +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == CNT_W'(VALUE_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(VALUE_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bin <= i_value;
            r_bcd <= '0;
        end else if (r_busy) begin
            r_bin <= {r_bin[VALUE_W-2:0], 1'b0};
            if (BCD_W > 1) begin
                r_bcd <= {n_adj[BCD_W-2:0], r_bin[VALUE_W-1]};
            end
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

>>> rtl/ddse_checker.sv
// Port-level checks for the decimal digit sprite emitter, bound to the top level.
module ddse_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input ddse_pkg::t_out_item             o_out_data
);
    import ddse_pkg::*;

    // busy right after an input transaction
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after transaction");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled output transaction changed");

    a_last_is_tpage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.last_record) |->
        (o_out_data.record_kind == KIND_TPAGE && o_out_data.sprite_x == '0 &&
         o_out_data.sprite_y == '0 && o_out_data.glyph_u == '0))
        else $error("closing record malformed");

    a_glyph_u: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.last_record) |->
        (o_out_data.glyph_u[2:0] == 3'd0 && o_out_data.glyph_u <= 7'd72 &&
         (o_out_data.record_kind == KIND_DIGIT || o_out_data.record_kind == KIND_OUTLINE)))
        else $error("sprite record malformed");

    a_tpage_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.record_kind == KIND_TPAGE) |-> o_out_data.last_record)
        else $error("texture page record not flagged last");

endmodule

bind decimal_digit_sprite_emitter ddse_checker u_ddse_checker (.*);

>>> sim/tb_decimal_digit_sprite_emitter.sv
// Self-checking testbench for the decimal digit sprite emitter: directed and random numbers.
module tb_decimal_digit_sprite_emitter;
    import ddse_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 5;
    localparam int TAIL_CYCLES    = 100;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_PAL_NORMAL;
    logic [WORD_W-1:0]    cfg_data = '0;

    // register copies used by the digit predictor
    logic [WORD_W-1:0] pal_normal = RST_PAL_NORMAL;
    logic [WORD_W-1:0] pal_one    = RST_PAL_ONE;
    logic [WORD_W-1:0] pal_two    = RST_PAL_TWO;
    logic [WORD_W-1:0] tpage_word = RST_TPAGE;

    t_in_item  pending_numbers[$];
    t_out_item sprite_records[$];
    t_out_item want_rec;

    int numbers_queued = 0;
    int numbers_taken = 0;
    int records_checked = 0;
    int mismatches = 0;
    int quiet_cycles = 0;
    int sender_idle_pct = 0;
    int receiver_idle_pct = 0;
    int hold_left = 0;
    bit hold_req = 1'b0;
    bit in_fire = 1'b0;

    decimal_digit_sprite_emitter i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #6 i_clk = ~i_clk;

    task automatic predict_sprites(input t_in_item it);
        int unsigned     w;
        int unsigned     nsig;
        int unsigned     pos;
        int unsigned     i;
        longint unsigned limit;
        longint unsigned val;
        longint unsigned div;
        longint unsigned d;
        logic [15:0]     pal;
        logic [15:0]     ex;
        logic [15:0]     x;
        t_out_item       r;
        w = it.digit_width;
        if (w < 1) w = 1;
        if (w > DEF_MAX_DIGITS) w = DEF_MAX_DIGITS;
        if (it.style_select == STYLE_ONE) pal = pal_one;
        else if (it.style_select == STYLE_TWO) pal = pal_two;
        else pal = pal_normal;
        limit = 1;
        for (i = 0; i < w; i++) limit *= 10;
        val = it.number_value;
        if (val >= limit) val = limit - 1;
        nsig = 1;
        div = 1;
        while (nsig < w && val >= div * 10) begin
            div *= 10;
            nsig++;
        end
        ex = 16'(it.start_x) + 16'(w * 8);
        for (pos = w - nsig; pos < w; pos++) begin
            d = val / div;
            x = 16'(it.start_x) + 16'(pos * 8);
            val -= d * div;
            div /= 10;
            if (div == 0) div = 1;
            r.record_kind  = KIND_DIGIT;
            r.sprite_x     = x;
            r.sprite_y     = it.start_y;
            r.glyph_u      = 7'(d * 8);
            r.palette_word = pal;
            r.end_x        = ex;
            r.last_record  = 1'b0;
            sprite_records.push_back(r);
            if (it.outline_enable) begin
                // right, left, down, up
                r.record_kind = KIND_OUTLINE;
                r.sprite_x = x + 16'd1;
                sprite_records.push_back(r);
                r.sprite_x = x - 16'd1;
                sprite_records.push_back(r);
                r.sprite_x = x;
                r.sprite_y = 16'(it.start_y) + 16'd1;
                sprite_records.push_back(r);
                r.sprite_y = 16'(it.start_y) - 16'd1;
                sprite_records.push_back(r);
            end
        end
        r = '0;
        r.record_kind  = KIND_TPAGE;
        r.palette_word = tpage_word;
        r.end_x        = ex;
        r.last_record  = 1'b1;
        sprite_records.push_back(r);
    endtask

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // monitor: input transactions feed the predictor, output transactions are checked
    always @(posedge i_clk) begin
        in_fire = 1'b0;
        if (i_rst_n) begin
            if (in_valid && !in_stall) begin
                predict_sprites(in_data);
                numbers_taken++;
                in_fire = 1'b1;
            end
            if (out_valid && !out_stall) begin
                if (sprite_records.size() == 0) begin
                    $error("record with no transaction pending: %p", out_data);
                    mismatches++;
                end else begin
                    want_rec = sprite_records.pop_front();
                    check_field("record_kind", want_rec.record_kind, out_data.record_kind);
                    check_field("sprite_x", want_rec.sprite_x, out_data.sprite_x);
                    check_field("sprite_y", want_rec.sprite_y, out_data.sprite_y);
                    check_field("glyph_u", want_rec.glyph_u, out_data.glyph_u);
                    check_field("palette_word", want_rec.palette_word, out_data.palette_word);
                    check_field("end_x", want_rec.end_x, out_data.end_x);
                    check_field("last_record", want_rec.last_record, out_data.last_record);
                    records_checked++;
                end
            end
            if (in_fire || (out_valid && !out_stall)) quiet_cycles = 0;
            else quiet_cycles++;
        end
    end

    always @(negedge i_clk) begin
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // driver: a stalled transaction is held as it is
    always @(negedge i_clk) begin
        if (!(in_valid && !in_fire)) begin
            if (pending_numbers.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                in_valid <= 1'b1;
                in_data  <= pending_numbers.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < receiver_idle_pct);
        end
    end

    function automatic t_in_item make_number(input logic [26:0] value, input logic [3:0] width,
                                             input logic [15:0] x, input logic [15:0] y,
                                             input logic [6:0] style, input logic outline);
        t_in_item it;
        it.number_value   = value;
        it.digit_width    = width;
        it.start_x        = x;
        it.start_y        = y;
        it.style_select   = style;
        it.outline_enable = outline;
        return it;
    endfunction

    function automatic t_in_item random_number();
        t_in_item    it;
        int unsigned k;
        int unsigned lo;
        int unsigned i;
        k = $urandom_range(1, 8);
        lo = 1;
        for (i = 1; i < k; i++) lo *= 10;
        it.digit_width = ($urandom_range(99) < 85) ? 4'($urandom_range(1, 8))
                                                   : 4'($urandom_range(0, 15));
        case ($urandom_range(7))
            0:       it.number_value = '0;
            1, 2, 3: it.number_value = 27'($urandom_range(lo * 10 - 1, (k == 1) ? 0 : lo));
            4:       it.number_value = 27'($urandom);
            5:       it.number_value = 27'($urandom_range(1) ? lo * 10 : lo * 10 - 1);
            default: it.number_value = 27'($urandom_range(99));
        endcase
        it.start_x = ($urandom_range(9) == 0) ? 16'(32'h7FF0 + $urandom_range(31))
                                              : 16'($urandom);
        it.start_y = ($urandom_range(9) == 0) ? 16'(32'h7FFE + $urandom_range(3))
                                              : 16'($urandom);
        it.style_select   = ($urandom_range(99) < 70) ? 7'($urandom_range(2)) : 7'($urandom);
        it.outline_enable = 1'($urandom_range(1));
        return it;
    endfunction

    task automatic add_number(input t_in_item it);
        pending_numbers.push_back(it);
        numbers_queued++;
    endtask

    task automatic add_random_numbers(input int count);
        int i;
        @(posedge i_clk);
        for (i = 0; i < count; i++) add_number(random_number());
    endtask

    task automatic wait_drained();
        while (numbers_taken != numbers_queued || sprite_records.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_PAL_NORMAL: pal_normal = value;
            CFG_PAL_ONE:    pal_one    = value;
            CFG_PAL_TWO:    pal_two    = value;
            CFG_TPAGE:      tpage_word = value;
            default:        ;
        endcase
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_palettes(input logic [15:0] normal, input logic [15:0] one,
                                input logic [15:0] two, input logic [15:0] tpage);
        write_reg(CFG_PAL_NORMAL, normal);
        write_reg(CFG_PAL_ONE, one);
        write_reg(CFG_PAL_TWO, two);
        write_reg(CFG_TPAGE, tpage);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        sender_idle_pct   = 17;
        receiver_idle_pct = 76;
        @(posedge i_clk);
        // directed: reset palettes, zero, saturation, clamped widths, styles, wrap
        add_number(make_number(27'd0, 4'd1, 16'h0000, 16'h0000, 7'd0, 1'b0));
        add_number(make_number(27'd0, 4'd8, 16'h0010, 16'h0020, 7'd1, 1'b1));
        add_number(make_number(27'd99999999, 4'd8, 16'h0100, 16'h0040, 7'd1, 1'b1));
        add_number(make_number(27'h7FFFFFF, 4'd8, 16'h0000, 16'h0000, 7'd2, 1'b0));
        add_number(make_number(27'd12345, 4'd3, 16'h0020, 16'h0030, 7'd0, 1'b0));
        add_number(make_number(27'd1234567, 4'd0, 16'h0040, 16'h0050, 7'd0, 1'b1));
        add_number(make_number(27'd7, 4'd15, 16'h0060, 16'h0070, 7'd2, 1'b0));
        add_number(make_number(27'd100000000, 4'd9, 16'h0000, 16'h0008, 7'd0, 1'b0));
        add_number(make_number(27'd4821, 4'd6, 16'h0080, 16'h0090, 7'd2, 1'b1));
        add_number(make_number(27'd350, 4'd4, 16'h00A0, 16'h00B0, 7'd127, 1'b1));
        add_number(make_number(27'd61, 4'd2, 16'h00C0, 16'h00D0, 7'd3, 1'b0));
        add_number(make_number(27'd8, 4'd1, 16'h7FFF, 16'h8000, 7'd0, 1'b1));
        add_number(make_number(27'd5, 4'd1, 16'h8000, 16'h7FFF, 7'd1, 1'b1));
        add_number(make_number(27'd87654321, 4'd8, 16'h7FF8, 16'hFFFF, 7'd0, 1'b0));
        add_number(make_number(27'd10, 4'd2, 16'hFFFF, 16'h0000, 7'd0, 1'b0));
        add_number(make_number(27'd9, 4'd1, 16'h0000, 16'h0001, 7'd0, 1'b0));
        add_number(make_number(27'd10, 4'd1, 16'h0004, 16'h0002, 7'd0, 1'b0));
        add_number(make_number(27'd1000000, 4'd7, 16'h0008, 16'h0003, 7'd64, 1'b0));
        add_number(make_number(27'd10000000, 4'd8, 16'h0010, 16'h0004, 7'd1, 1'b1));
        add_number(make_number(27'd5, 4'd8, 16'h0020, 16'h0005, 7'd0, 1'b0));
        wait_drained();

        set_palettes(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        add_random_numbers(75);
        wait_drained();
        write_reg(CFG_TPAGE, 16'($urandom));
        add_random_numbers(75);
        wait_drained();

        sender_idle_pct   = 76;
        receiver_idle_pct = 17;
        set_palettes(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        add_random_numbers(150);
        wait_drained();

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        set_palettes(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_random_numbers(80);
        hold_req = 1'b1;
        wait_drained();
        set_palettes(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        add_random_numbers(80);
        wait_drained();

        repeat (TAIL_CYCLES) @(negedge i_clk);
        $display("Checked %0d sprite records from %0d numbers under five register settings",
                 records_checked, numbers_taken);
        $display("with saturation, blanking, width clamp, outlines and wrap; %0d mismatches",
                 mismatches);
        if (mismatches == 0 && sprite_records.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/ddse_pkg.sv
rtl/ddse_bcd_conv.sv
rtl/decimal_digit_sprite_emitter.sv
rtl/ddse_checker.sv
sim/tb_decimal_digit_sprite_emitter.sv
